// ----- hdl/hmvg_pkg.sv -----
// Shared types and constants for the heightmap mesh vertex generator.
// Used by the height store, height converter, divide/sqrt unit and top level.
package hmvg_pkg;

	localparam int MAX_SIZE = 128;
	localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int SUM_W    = 10;
	localparam int H_W      = 16;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 176;

	// Divide/sqrt unit widths.
	localparam int REM_W  = 35;
	localparam int SRC_W  = 32;
	localparam int DIVR_W = 34;
	localparam int QUO_W  = 31;

	// Height scaling: round(sum * max_height / 765) by reciprocal and one correction.
	localparam logic [17:0] RECIP_765   = 18'd175448;
	localparam int          RECIP_SHIFT = 27;
	localparam logic [9:0]  DIV_765     = 10'd765;
	localparam logic [8:0]  ROUND_382   = 9'd382;

	// Square of the fixed normal y component (3 * 256).
	localparam logic [19:0] NY_SQ = 20'd589824;

	localparam logic [4:0] DIV_STEPS  = 5'd30;
	localparam logic [4:0] SQRT_STEPS = 5'd15;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EMIT = 1'b1;

	localparam logic CFG_GRID_SIZE  = 1'b0;
	localparam logic CFG_MAX_HEIGHT = 1'b1;

	typedef enum logic {
		OP_DIV,
		OP_SQRT
	} dsu_op_t;

	typedef struct packed {
		logic    start;
		dsu_op_t op;
	} dsu_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} dsu_rsp_t;

endpackage

// ----- hdl/hmvg_hstore.sv -----
// Height store: one write port for loaded pixel sums, one registered read port.
// Depends on hmvg_pkg for depth and widths.
module hmvg_hstore (
	input  logic                          clk,
	input  logic                          we,
	input  logic [hmvg_pkg::ADDR_W-1:0]   waddr,
	input  logic [hmvg_pkg::SUM_W-1:0]    wdata,
	input  logic [hmvg_pkg::ADDR_W-1:0]   raddr,
	output logic [hmvg_pkg::SUM_W-1:0]    rdata
);
	import hmvg_pkg::*;

	logic [SUM_W-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/hmvg_hconv.sv -----
// Four-stage pipeline turning a pixel sum into a height in 1/256 units.
// Depends on hmvg_pkg for the reciprocal constants.
module hmvg_hconv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [hmvg_pkg::SUM_W-1:0] sum,
	input  logic [15:0]                max_height,
	output logic                       out_valid,
	output logic [hmvg_pkg::H_W-1:0]   height
);
	import hmvg_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [25:0] p_s1, n_s2;
	logic [16:0] q_s2, q_s3;
	logic [25:0] r_s3;
	logic [H_W-1:0] h_s4;
	logic [43:0] prod_recip;
	logic [26:0] prod_back;
	logic [16:0] q_fix;

	assign prod_recip = p_s1 * RECIP_765;
	assign prod_back  = q_s2 * DIV_765;
	assign q_fix      = q_s3 + ((r_s3 >= 26'(DIV_765)) ? 17'd1 : 17'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= 26'(sum * max_height) + 26'(ROUND_382);
		q_s2 <= prod_recip[RECIP_SHIFT +: 17];
		n_s2 <= p_s1;
		q_s3 <= q_s2;
		r_s3 <= n_s2 - prod_back[25:0];
		h_s4 <= q_fix[H_W-1:0];
	end

	assign out_valid = v_s4;
	assign height    = h_s4;

endmodule

// ----- hdl/hmvg_dsu.sv -----
// Shared iterative unit: restoring division one bit a step, and integer
// square root two bits a step, both on one compare-and-subtract. Uses hmvg_pkg.
module hmvg_dsu (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hmvg_pkg::dsu_req_t          req,
	input  logic [hmvg_pkg::REM_W-1:0]  rem0,
	input  logic [hmvg_pkg::SRC_W-1:0]  src,
	input  logic [hmvg_pkg::DIVR_W-1:0] divisor,
	output hmvg_pkg::dsu_rsp_t          rsp
);
	import hmvg_pkg::*;

	logic              busy_q, done_q;
	logic [4:0]        cnt_q;
	dsu_op_t           op_q;
	logic [REM_W-1:0]  rem_q;
	logic [SRC_W-1:0]  src_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DIVR_W-1:0] div_q;
	logic [REM_W-1:0]  cand, sub, nrem;
	logic              ge;

	always_comb begin
		if (op_q == OP_DIV) begin
			cand = {rem_q[REM_W-2:0], src_q[SRC_W-1]};
			sub  = {1'b0, div_q};
		end else begin
			cand = {rem_q[REM_W-3:0], src_q[SRC_W-1 -: 2]};
			sub  = REM_W'({quo_q[15:0], 2'b01});
		end
		ge   = cand >= sub;
		nrem = ge ? cand - sub : cand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_DIV;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_DIV) ? DIV_STEPS : SQRT_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= rem0;
			src_q <= src;
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= nrem;
			src_q <= (op_q == OP_DIV) ? {src_q[SRC_W-2:0], 1'b0} : {src_q[SRC_W-3:0], 2'b00};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- hdl/heightmap_mesh_vertex_generator.sv -----
// Top level of the heightmap mesh vertex generator: stream ports, config,
// vertex sequencer. Depends on hmvg_pkg, hmvg_hstore, hmvg_hconv and hmvg_dsu.
//
// A load beat (tuser 0) writes red+green+blue into the height store at an
// auto-incrementing address that wraps after side squared pixels (side is
// grid_size clamped to 2..MAX_SIZE); s_tready stays high. An emit beat
// (tuser 1) names a cell and the block answers with six vertex beats, TL,
// BL, BR, BR, TR, TL, the sixth flagged with m_tlast. An emit fetches four
// corner heights and then, per vertex, five heights through the registered
// store read and the four-stage height pipeline, then three normal components
// of one 31-step division and one 16-step square root each, then two 31-step
// divisions for u and v, all on the single shared divide/sqrt unit. The
// block takes no new beat until the last vertex of a cell has been taken.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
module heightmap_mesh_vertex_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata: red[7:0], green[15:8], blue[23:16], cell_x[30:24], cell_z[37:31]
	input  logic [hmvg_pkg::S_DATA_W-1:0] s_tdata,
	// s_tuser: req_type[0]
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: pos_x[15:0], pos_y[31:16], pos_z[47:32], tex_u[64:48],
	// tex_v[81:65], norm_x[97:82], norm_y[112:98], norm_z[128:113],
	// tan_x[144:129], tan_y[168:145], zero pad above
	output logic [hmvg_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);
	import hmvg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FADDR, ST_FMEM, ST_FWAIT, ST_SQX, ST_SQZ, ST_LEN,
		ST_DIV, ST_DIVW, ST_SQRT, ST_SQRTW, ST_PACK, ST_OUT
	} state_t;

	state_t state_q;

	// Configuration and the side length in use.
	logic [7:0]  grid_q;
	logic [15:0] maxh_q;
	logic [7:0]  side;
	logic [15:0] total;

	assign side  = (grid_q < 8'd2) ? 8'd2 :
	               (grid_q > 8'(MAX_SIZE)) ? 8'(MAX_SIZE) : grid_q;
	assign total = side * side;

	// Input beat decode.
	logic load_fire, emit_fire;
	logic [SUM_W-1:0] pix_sum;
	logic [6:0] in_cx, in_cz, cmax;

	assign s_tready  = (state_q == ST_IDLE);
	assign load_fire = s_tvalid && s_tready && (s_tuser[0] == REQ_LOAD);
	assign emit_fire = s_tvalid && s_tready && (s_tuser[0] == REQ_EMIT);
	assign pix_sum   = SUM_W'(s_tdata[7:0]) + SUM_W'(s_tdata[15:8]) + SUM_W'(s_tdata[23:16]);
	assign in_cx     = s_tdata[30:24];
	assign in_cz     = s_tdata[37:31];
	assign cmax      = 7'(side - 8'd2);

	// Write pointer: a pointer left beyond the grid by a shrink restarts at zero.
	logic [ADDR_W-1:0] wp_q, wp_eff, wp_next;
	logic [15:0]       wp_inc;

	assign wp_eff  = (16'(wp_q) >= total) ? '0 : wp_q;
	assign wp_inc  = 16'(wp_eff) + 16'd1;
	assign wp_next = (wp_inc >= total) ? '0 : wp_inc[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= 8'd128;
			maxh_q <= 16'd256;
			wp_q   <= '0;
		end else begin
			if (cfg_we && cfg_index[0] == CFG_GRID_SIZE) begin
				grid_q <= cfg_data[7:0];
			end
			if (cfg_we && cfg_index[0] == CFG_MAX_HEIGHT) begin
				maxh_q <= cfg_data;
			end
			if (load_fire) begin
				wp_q <= wp_next;
			end
		end
	end

	// Sequencer registers.
	logic       corner_q;
	logic [2:0] vtx_q, k_q, comp_q;

	// Datapath registers.
	logic [6:0]      cx_q, cz_q;
	logic [H_W-1:0]  hv_q [0:4];   // center, left, right, up, down
	logic [H_W-1:0]  hc_q [0:3];   // TL, BL, BR, TR
	logic [31:0]     ax2_q, az2_q;
	logic [33:0]     len2_q;
	logic [15:0]     nq_q [0:2];
	logic [16:0]     tu_q, tv_q;

	// Grid point of the vertex (or corner) being worked on.
	logic [2:0] vsel, k_eff;
	logic [7:0] gx, gz;
	logic [8:0] fz;
	logic signed [9:0] dx, dz, px, pz;
	logic [6:0] xc, zc;
	logic [14:0] rd_lin;
	logic [ADDR_W-1:0] raddr;

	function automatic logic [6:0] clamp_coord(input logic signed [9:0] p, input logic [7:0] s);
		logic signed [9:0] hi;
		hi = $signed({2'b00, s}) - 10'sd1;
		if (p < 10'sd0) begin
			return 7'd0;
		end else if (p > hi) begin
			return hi[6:0];
		end
		return p[6:0];
	endfunction

	always_comb begin
		vsel  = corner_q ? ((k_q == 3'd3) ? 3'd4 : k_q) : vtx_q;
		k_eff = corner_q ? 3'd0 : k_q;
		gx    = {1'b0, cx_q} + ((vsel inside {3'd2, 3'd3, 3'd4}) ? 8'd1 : 8'd0);
		gz    = {1'b0, cz_q} + ((vsel inside {3'd1, 3'd2, 3'd3}) ? 8'd1 : 8'd0);
		fz    = {1'b0, side} - {1'b0, gz};
		dx    = 10'sd0;
		dz    = 10'sd0;
		case (k_eff)
			3'd1: dx = -10'sd1;
			3'd2: dx = 10'sd1;
			3'd3: dz = 10'sd1;
			3'd4: dz = -10'sd1;
			default: begin
				dx = 10'sd0;
				dz = 10'sd0;
			end
		endcase
		px     = $signed({2'b00, gx}) + dx;
		pz     = $signed({1'b0, fz}) + dz;
		xc     = clamp_coord(px, side);
		zc     = clamp_coord(pz, side);
		rd_lin = zc * side + 15'(xc);
		raddr  = rd_lin[ADDR_W-1:0];
	end

	// Height store and converter.
	logic [SUM_W-1:0] rd_sum;
	logic             conv_valid;
	logic [H_W-1:0]   conv_h;

	hmvg_hstore u_store (
		.clk   (clk),
		.we    (load_fire),
		.waddr (wp_eff),
		.wdata (pix_sum),
		.raddr (raddr),
		.rdata (rd_sum)
	);

	hmvg_hconv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (state_q == ST_FMEM),
		.sum        (rd_sum),
		.max_height (maxh_q),
		.out_valid  (conv_valid),
		.height     (conv_h)
	);

	// Normal differences and the squaring multiplier.
	logic signed [16:0] nx, nz;
	logic [15:0] ax, az, sq_in;
	logic [31:0] sq;

	assign nx    = $signed({1'b0, hv_q[1]}) - $signed({1'b0, hv_q[2]});
	assign nz    = $signed({1'b0, hv_q[4]}) - $signed({1'b0, hv_q[3]});
	assign ax    = nx[16] ? 16'(-nx) : nx[15:0];
	assign az    = nz[16] ? 16'(-nz) : nz[15:0];
	assign sq_in = (state_q == ST_SQX) ? ax : az;
	assign sq    = sq_in * sq_in;

	// Operands of the shared divide/sqrt unit.
	dsu_req_t          dsu_req;
	dsu_rsp_t          dsu_rsp;
	logic [REM_W-1:0]  dsu_rem0;
	logic [SRC_W-1:0]  dsu_src;
	logic [DIVR_W-1:0] dsu_div;
	logic [31:0]       a2;
	logic [25:0]       tex_num;

	always_comb begin
		case (comp_q)
			3'd0:    a2 = ax2_q;
			3'd1:    a2 = 32'(NY_SQ);
			default: a2 = az2_q;
		endcase
		// u and v: round(coord * 65536 / S) as (coord * 131072 + S) / (2S).
		tex_num       = {((comp_q == 3'd3) ? {1'b0, gx} : fz), 17'd0} + 26'(side);
		dsu_req.start = (state_q == ST_DIV) || (state_q == ST_SQRT);
		dsu_req.op    = (state_q == ST_SQRT) ? OP_SQRT : OP_DIV;
		if (state_q == ST_SQRT) begin
			dsu_rem0 = '0;
			dsu_src  = {1'b0, dsu_rsp.quo};
			dsu_div  = '0;
		end else if (comp_q < 3'd3) begin
			// Quotient of a^2 * 2^30 over the squared length.
			dsu_rem0 = REM_W'(a2[31:1]);
			dsu_src  = {a2[0], 31'd0};
			dsu_div  = len2_q;
		end else begin
			dsu_rem0 = '0;
			dsu_src  = {5'd0, tex_num, 1'b0};
			dsu_div  = DIVR_W'({side, 1'b0});
		end
	end

	hmvg_dsu u_dsu (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (dsu_req),
		.rem0    (dsu_rem0),
		.src     (dsu_src),
		.divisor (dsu_div),
		.rsp     (dsu_rsp)
	);

	// Output fields of the current vertex.
	logic signed [16:0] dh;
	logic signed [25:0] tany;
	logic [16:0] posx, posz;
	logic [15:0] normx, normz, sat0, sat1, sat2;
	logic [M_DATA_W-1:0] packed_vtx;

	function automatic logic [15:0] sat15(input logic [15:0] q);
		return (q > 16'd32767) ? 16'd32767 : q;
	endfunction

	always_comb begin
		dh    = (vtx_q < 3'd3) ? ($signed({1'b0, hc_q[2]}) - $signed({1'b0, hc_q[1]}))
		                       : ($signed({1'b0, hc_q[3]}) - $signed({1'b0, hc_q[0]}));
		tany  = $signed({1'b0, side}) * dh;
		posx  = 17'({gx, 8'd0}) - 17'({side, 7'd0});
		posz  = 17'({gz, 8'd0}) - 17'({side, 7'd0});
		sat0  = sat15(nq_q[0]);
		sat1  = sat15(nq_q[1]);
		sat2  = sat15(nq_q[2]);
		normx = nx[16] ? 16'(16'd0 - nq_q[0]) : sat0;
		normz = nz[16] ? 16'(16'd0 - nq_q[2]) : sat2;
		packed_vtx = {7'd0, tany[23:0], 16'({side, 8'd0}), normz, sat1[14:0], normx,
		              tv_q, tu_q, posz[15:0], hv_q[0], posx[15:0]};
	end

	// Datapath captures.
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			cx_q <= (in_cx > cmax) ? cmax : in_cx;
			cz_q <= (in_cz > cmax) ? cmax : in_cz;
		end
		if (state_q == ST_FWAIT && conv_valid) begin
			if (corner_q) begin
				hc_q[k_q[1:0]] <= conv_h;
			end else begin
				hv_q[k_q] <= conv_h;
			end
		end
		if (state_q == ST_SQX) begin
			ax2_q <= sq;
		end
		if (state_q == ST_SQZ) begin
			az2_q <= sq;
		end
		if (state_q == ST_LEN) begin
			len2_q <= 34'(ax2_q) + 34'(az2_q) + 34'(NY_SQ);
		end
		if (state_q == ST_SQRTW && dsu_rsp.done) begin
			nq_q[comp_q[1:0]] <= dsu_rsp.quo[15:0];
		end
		if (state_q == ST_DIVW && dsu_rsp.done && comp_q == 3'd3) begin
			tu_q <= dsu_rsp.quo[16:0];
		end
		if (state_q == ST_DIVW && dsu_rsp.done && comp_q == 3'd4) begin
			tv_q <= dsu_rsp.quo[16:0];
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= 1'b0;
			vtx_q    <= '0;
			k_q      <= '0;
			comp_q   <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (emit_fire) begin
						corner_q <= 1'b1;
						k_q      <= '0;
						vtx_q    <= '0;
						state_q  <= ST_FADDR;
					end
				end
				ST_FADDR: state_q <= ST_FMEM;
				ST_FMEM:  state_q <= ST_FWAIT;
				ST_FWAIT: begin
					if (conv_valid) begin
						if (corner_q) begin
							if (k_q == 3'd3) begin
								corner_q <= 1'b0;
								k_q      <= '0;
							end else begin
								k_q <= k_q + 3'd1;
							end
							state_q <= ST_FADDR;
						end else if (k_q == 3'd4) begin
							k_q     <= '0;
							state_q <= ST_SQX;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= ST_FADDR;
						end
					end
				end
				ST_SQX: state_q <= ST_SQZ;
				ST_SQZ: state_q <= ST_LEN;
				ST_LEN: begin
					comp_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (dsu_rsp.done) begin
						if (comp_q < 3'd3) begin
							state_q <= ST_SQRT;
						end else if (comp_q == 3'd3) begin
							comp_q  <= 3'd4;
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_PACK;
						end
					end
				end
				ST_SQRT: state_q <= ST_SQRTW;
				ST_SQRTW: begin
					if (dsu_rsp.done) begin
						comp_q  <= comp_q + 3'd1;
						state_q <= ST_DIV;
					end
				end
				ST_PACK: begin
					m_tvalid <= 1'b1;
					m_tdata  <= packed_vtx;
					m_tlast  <= (vtx_q == 3'd5);
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (vtx_q == 3'd5) begin
							state_q <= ST_IDLE;
						end else begin
							vtx_q   <= vtx_q + 3'd1;
							state_q <= ST_FADDR;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A vertex beat is only ever offered while the block is busy with a cell.
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("vertex offered while input side is ready");

	// An accepted emit beat makes the block busy.
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == REQ_EMIT) |=> !s_tready)
		else $error("emit beat did not start the sequencer");

	// After the last vertex of a cell is taken the block is ready again.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("block not idle after last vertex");

	// The shared unit only finishes while the sequencer waits for it.
	a_dsu_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dsu_rsp.done |-> (state_q == ST_DIVW || state_q == ST_SQRTW))
		else $error("divide/sqrt result arrived outside a wait state");

endmodule

// ----- sim/hmvg_vertex_checker.sv -----
// Scoreboard for the heightmap mesh vertex generator: watches the config port
// and both streams, predicts the vertex beats and compares them. Needs hmvg_pkg.
module hmvg_vertex_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [hmvg_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [0:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [hmvg_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	output int                            mismatches,
	output int                            vertices_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import hmvg_pkg::*;

	typedef struct {
		logic [168:0] fields;
		logic         last;
	} vertex_t;

	localparam int NFIELD = 10;
	localparam int FOFF [NFIELD] = '{0, 16, 32, 48, 65, 82, 98, 113, 129, 145};
	localparam int FWID [NFIELD] = '{16, 16, 16, 17, 17, 16, 15, 16, 16, 24};
	localparam string FNAME [NFIELD] = '{"pos_x", "pos_y", "pos_z", "tex_u", "tex_v",
		"norm_x", "norm_y", "norm_z", "tan_x", "tan_y"};

	logic [9:0]  heights [DEPTH];
	int unsigned wr_ptr;
	logic [7:0]  grid_reg;
	logic [15:0] peak_reg;
	int          side;
	int          mismatch_count = 0;
	vertex_t     owed [$];

	assign vertices_owed = owed.size();
	assign mismatches    = mismatch_count;

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Scaled height of a grid point; coordinates outside the grid clamp to its edge.
	function automatic int height_of(int x, int z);
		int xi;
		int zi;
		longint unsigned acc;
		xi = clampi(x, 0, side - 1);
		zi = clampi(z, 0, side - 1);
		acc = heights[(zi * side + xi) % DEPTH];
		return int'((acc * peak_reg + 382) / 765);
	endfunction

	// Q1.15 component d/sqrt(len2), truncated toward zero by a search on squares.
	function automatic longint unsigned unit_comp(int d, longint unsigned len2, bit sgn);
		longint unsigned a;
		longint unsigned num;
		longint unsigned m;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		a = d < 0 ? longint'(-d) : longint'(d);
		num = (a * a) << 30;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			m = longint'(mid) * mid;
			if (m * len2 <= num) lo = mid;
			else hi = mid - 1;
		end
		if (d < 0 && sgn) return (65536 - lo) & 16'hFFFF;
		if (lo > 32767) lo = 32767;
		return lo;
	endfunction

	function automatic vertex_t vertex_at(int gx, int gz, int dh, bit last);
		vertex_t v;
		int fz;
		int half;
		int nx;
		int nz;
		longint unsigned len2;
		fz = side - gz;
		half = side * 128;
		nx = height_of(gx - 1, fz) - height_of(gx + 1, fz);
		nz = height_of(gx, fz - 1) - height_of(gx, fz + 1);
		len2 = longint'(nx) * nx + 589824 + longint'(nz) * nz;
		v.fields = '0;
		v.fields[15:0]    = 16'(gx * 256 - half);
		v.fields[31:16]   = 16'(height_of(gx, fz));
		v.fields[47:32]   = 16'(gz * 256 - half);
		v.fields[64:48]   = 17'((longint'(gx) * 131072 + side) / (2 * side));
		v.fields[81:65]   = 17'((longint'(fz) * 131072 + side) / (2 * side));
		v.fields[97:82]   = 16'(unit_comp(nx, len2, 1'b1));
		v.fields[112:98]  = 15'(unit_comp(768, len2, 1'b0));
		v.fields[128:113] = 16'(unit_comp(nz, len2, 1'b1));
		v.fields[144:129] = 16'(side * 256);
		v.fields[168:145] = 24'(side * dh);
		v.last = last;
		return v;
	endfunction

	// Load beats write the store; emit beats queue the six vertices of the cell.
	task automatic take_request(logic [S_DATA_W-1:0] d, logic kind);
		int cx;
		int cz;
		int d1;
		int d2;
		int unsigned total;
		side = clampi(int'(grid_reg), 2, MAX_SIZE);
		if (kind == REQ_LOAD) begin
			total = side * side;
			if (wr_ptr >= total) wr_ptr = 0;
			heights[wr_ptr % DEPTH] = 10'(d[7:0]) + 10'(d[15:8]) + 10'(d[23:16]);
			wr_ptr++;
			if (wr_ptr >= total) wr_ptr = 0;
		end else begin
			cx = int'(d[30:24]);
			cz = int'(d[37:31]);
			if (cx > side - 2) cx = side - 2;
			if (cz > side - 2) cz = side - 2;
			d1 = height_of(cx + 1, side - cz - 1) - height_of(cx, side - cz - 1);
			d2 = height_of(cx + 1, side - cz) - height_of(cx, side - cz);
			owed = {owed, vertex_at(cx, cz, d1, 1'b0)};
			owed = {owed, vertex_at(cx, cz + 1, d1, 1'b0)};
			owed = {owed, vertex_at(cx + 1, cz + 1, d1, 1'b0)};
			owed = {owed, vertex_at(cx + 1, cz + 1, d2, 1'b0)};
			owed = {owed, vertex_at(cx + 1, cz, d2, 1'b0)};
			owed = {owed, vertex_at(cx, cz, d2, 1'b1)};
		end
	endtask

	task automatic report(string what, longint unsigned want, longint unsigned got);
		if (mismatch_count < 10)
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
		mismatch_count++;
	endtask

	task automatic check_vertex(logic [M_DATA_W-1:0] d, logic last);
		vertex_t want;
		logic [168:0] mask;
		longint unsigned a;
		longint unsigned b;
		if (owed.size() == 0) begin
			if (mismatch_count < 10) $display("%0t: vertex beat with none expected", $realtime);
			mismatch_count++;
			return;
		end
		want = owed.pop_front();
		for (int f = 0; f < NFIELD; f++) begin
			mask = (169'(1) << FWID[f]) - 1;
			a = longint'((want.fields >> FOFF[f]) & mask);
			b = longint'((d[168:0] >> FOFF[f]) & mask);
			if (a != b) report(FNAME[f], a, b);
		end
		if (want.last != last) report("last_of_cell", want.last, last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr = 0;
			grid_reg = 8'd128;
			peak_reg = 16'd256;
			owed.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_GRID_SIZE) grid_reg = cfg_data[7:0];
				else peak_reg = cfg_data;
			end
			if (s_tvalid && s_tready) take_request(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready) check_vertex(m_tdata, m_tlast);
		end
	end

endmodule

// ----- sim/tb_heightmap_mesh_vertex_generator.sv -----
// Top of the testbench for the heightmap mesh vertex generator: clock, reset,
// stimulus and verdict. Needs hmvg_pkg, the RTL and hmvg_vertex_checker.
module tb_heightmap_mesh_vertex_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import hmvg_pkg::*;

	// An emit, even with six long output stalls on top, ends well inside this
	// limit; a quiet stretch beyond it means the block has hung.
	localparam int QUIET_LIMIT = 20000;

	// Side of the grid that is filled first; no later size goes above it.
	localparam int FILL_SIDE = 10;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [0:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [15:0]         cfg_data;
	int                  mismatches;
	int                  vertices_owed;

	bit no_gaps;
	int stall_left = 0;
	int quiet_cycles = 0;

	heightmap_mesh_vertex_generator dut (.*);

	hmvg_vertex_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Mostly short gaps, sometimes a long one; none at all during a burst.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// The vertex sink stalls at random, with occasional stretches of no stall.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!no_gaps && $urandom_range(0, 99) < 30) begin
			stall_left <= pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: counts cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// One request beat. tvalid stays high between back-to-back beats.
	task automatic send_beat(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic [6:0] cx, logic [6:0] cz);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, cz, cx, b, g, r};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		send_beat(REQ_LOAD, r, g, b, 7'($urandom), 7'($urandom));
	endtask

	task automatic emit_cell(logic [6:0] cx, logic [6:0] cz);
		send_beat(REQ_EMIT, 8'($urandom), 8'($urandom), 8'($urandom), cx, cz);
	endtask

	// Drain the block, then give the last load time to land before reconfiguring.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (vertices_owed != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_cell();
		if ($urandom_range(0, 3) == 0) emit_cell(7'($urandom), 7'($urandom));
		else emit_cell(7'($urandom_range(0, 15)), 7'($urandom_range(0, 15)));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_gaps = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill a small grid; every later size stays at or below it, so no emit
		// ever reads an entry that was never written. The first pixels hit the
		// color extremes.
		write_reg(CFG_GRID_SIZE, 16'(FILL_SIDE));
		write_reg(CFG_MAX_HEIGHT, 16'd256);
		load_pixel(8'd0, 8'd0, 8'd0);
		load_pixel(8'd255, 8'd255, 8'd255);
		load_pixel(8'd255, 8'd0, 8'd0);
		load_pixel(8'd0, 8'd255, 8'd0);
		load_pixel(8'd0, 8'd0, 8'd255);
		no_gaps = 1'b1;
		for (int i = 5; i < FILL_SIDE * FILL_SIDE; i++) begin
			if (i % 32 == 0) no_gaps = ~no_gaps;
			load_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		end
		no_gaps = 1'b0;

		// Corners and saturation of the cell coordinates at the filled size.
		emit_cell(7'd0, 7'd0);
		emit_cell(7'(FILL_SIDE - 2), 7'(FILL_SIDE - 2));
		emit_cell(7'd127, 7'd127);
		emit_cell(7'd0, 7'd127);
		emit_cell(7'd127, 7'd0);
		emit_cell(7'd5, 7'd3);
		// A few more loads leave the pointer beyond the end of a two by two grid.
		load_pixel(8'd10, 8'd20, 8'd30);
		load_pixel(8'd255, 8'd255, 8'd0);
		load_pixel(8'd7, 8'd0, 8'd99);
		load_pixel(8'd128, 8'd128, 8'd128);
		load_pixel(8'd3, 8'd250, 8'd60);
		settle();

		// Smallest grid with the tallest terrain; the pointer restarts and wraps.
		write_reg(CFG_GRID_SIZE, 16'd2);
		write_reg(CFG_MAX_HEIGHT, 16'd65535);
		emit_cell(7'd0, 7'd0);
		load_pixel(8'd255, 8'd255, 8'd255);
		load_pixel(8'd0, 8'd0, 8'd0);
		load_pixel(8'd200, 8'd17, 8'd255);
		load_pixel(8'd1, 8'd2, 8'd3);
		load_pixel(8'd99, 8'd0, 8'd255);
		emit_cell(7'd127, 7'd3);
		settle();

		// A size below the range clamps to two; a flat world with zero height.
		write_reg(CFG_GRID_SIZE, 16'd0);
		write_reg(CFG_MAX_HEIGHT, 16'd0);
		emit_cell(7'd1, 7'd0);
		settle();
		write_reg(CFG_GRID_SIZE, 16'(FILL_SIDE));
		write_reg(CFG_MAX_HEIGHT, 16'd65535);
		emit_cell(7'd127, 7'd64);
		emit_cell(7'd3, 7'd126);
		settle();

		// Random phases: random sizes and heights, a mix of loads and emits.
		for (int p = 0; p < 4; p++) begin
			if ($urandom_range(0, 4) == 0) write_reg(CFG_GRID_SIZE, 16'($urandom_range(0, 1)));
			else write_reg(CFG_GRID_SIZE, 16'($urandom_range(2, FILL_SIDE)));
			case ($urandom_range(0, 3))
				0: write_reg(CFG_MAX_HEIGHT, 16'd65535);
				1: write_reg(CFG_MAX_HEIGHT, 16'($urandom_range(0, 4)));
				default: write_reg(CFG_MAX_HEIGHT, 16'($urandom));
			endcase
			no_gaps = (p == 2);
			for (int i = 0; i < 20; i++) begin
				if ($urandom_range(0, 9) < 4) load_pixel(8'($urandom), 8'($urandom), 8'($urandom));
				else random_cell();
			end
			no_gaps = 1'b0;
			settle();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && vertices_owed == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
